@@ sv/tscf_pkg.sv @@
package tscf_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned FRAME_W = 11;
	localparam int unsigned CRC_W   = 16;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 24;

	localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
	localparam logic [CHAR_W-1:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		ST_CHAR,
		ST_STAR,
		ST_HEX3,
		ST_HEX2,
		ST_HEX1,
		ST_HEX0,
		ST_NL
	} emit_state_t;

	typedef struct packed {
		logic load;   // commit crc_next (or restart) into the running CRC
		logic clear;  // sentence ends: restart at CRC_INIT
	} crc_ctl_t;

	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
			input logic [CHAR_W-1:0] ch);
		logic [CRC_W-1:0] c;
		c = crc ^ {ch, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
	endfunction

	function automatic logic [FRAME_W-1:0] line_frame(input logic [CHAR_W-1:0] ch);
		return {2'b11, ch, 1'b0};
	endfunction

endpackage

@@ sv/telemetry_sentence_crc_framer_core.sv @@
// A request is registered at the input when accepted and loaded into the output register when it is taken.
// Throughput: one request per cycle while the output is not stalled; a request with tlast set yields seven
// results in order and holds the input while the six trailer results go out.
// The CRC is a combinational byte update between the input and output registers.
// Reset (arst_n low) clears both valid bits, the trailer sequencer, and sets the CRC to 0xFFFF.
module telemetry_sentence_crc_framer_core
	import tscf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] char_byte
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_char, [18:8] line_frame, pad
	output logic                   m_axis_tlast
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              take;
	logic              accept;
	crc_ctl_t          crc_ctl;
	logic [CRC_W-1:0]  crc_next;
	logic [CHAR_W-1:0] out_char;
	logic [FRAME_W-1:0] out_frame;

	assign s_axis_tready = !valid_s1 || take;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= s_axis_tdata[CHAR_W-1:0];
			last_s1 <= s_axis_tlast;
		end
	end

	tscf_crc u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.char_byte (char_s1),
		.crc_next  (crc_next)
	);

	tscf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.char_s1   (char_s1),
		.last_s1   (last_s1),
		.crc_next  (crc_next),
		.take      (take),
		.crc_ctl   (crc_ctl),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_frame (out_frame),
		.out_eos   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-CHAR_W-FRAME_W){1'b0}}, out_frame, out_char};

endmodule

@@ sv/tscf_crc.sv @@
module tscf_crc
	import tscf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  crc_ctl_t          ctl,
	input  logic [CHAR_W-1:0] char_byte,
	output logic [CRC_W-1:0]  crc_next
);

	logic [CRC_W-1:0] crc_q;

	// '$' is framed but skipped by the CRC
	assign crc_next = (char_byte == CHAR_DOLLAR) ? crc_q : crc_feed(crc_q, char_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.load) begin
			crc_q <= ctl.clear ? CRC_INIT : crc_next;
		end
	end

endmodule

@@ sv/tscf_emit.sv @@
module tscf_emit
	import tscf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [CHAR_W-1:0] char_s1,
	input  logic              last_s1,
	input  logic [CRC_W-1:0]  crc_next,
	output logic              take,
	output crc_ctl_t          crc_ctl,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic [FRAME_W-1:0] out_frame,
	output logic              out_eos
);

	emit_state_t      state_q, state_d;
	logic [CRC_W-1:0] tcrc_q;
	logic             m_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic             eos_q;
	logic             out_free;
	logic             load;
	logic [CHAR_W-1:0] ld_char;
	logic             ld_eos;

	assign out_free = !m_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CHAR: if (out_free && valid_s1 && last_s1) state_d = ST_STAR;
			ST_STAR: if (out_free) state_d = ST_HEX3;
			ST_HEX3: if (out_free) state_d = ST_HEX2;
			ST_HEX2: if (out_free) state_d = ST_HEX1;
			ST_HEX1: if (out_free) state_d = ST_HEX0;
			ST_HEX0: if (out_free) state_d = ST_NL;
			ST_NL:   if (out_free) state_d = ST_CHAR;
			default: state_d = ST_CHAR;
		endcase
	end

	always_comb begin
		take    = 1'b0;
		load    = 1'b0;
		ld_char = char_s1;
		ld_eos  = 1'b0;
		case (state_q)
			ST_CHAR: begin
				take = out_free && valid_s1;
				load = take;
			end
			ST_STAR: begin
				load    = out_free;
				ld_char = CHAR_STAR;
			end
			ST_HEX3: begin
				load    = out_free;
				ld_char = hex_char(tcrc_q[15:12]);
			end
			ST_HEX2: begin
				load    = out_free;
				ld_char = hex_char(tcrc_q[11:8]);
			end
			ST_HEX1: begin
				load    = out_free;
				ld_char = hex_char(tcrc_q[7:4]);
			end
			ST_HEX0: begin
				load    = out_free;
				ld_char = hex_char(tcrc_q[3:0]);
			end
			ST_NL: begin
				load    = out_free;
				ld_char = CHAR_NEWLINE;
				ld_eos  = 1'b1;
			end
			default: begin
				load = 1'b0;
			end
		endcase
		crc_ctl.load  = take;
		crc_ctl.clear = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CHAR;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= ld_char;
			eos_q  <= ld_eos;
		end
		if (take && last_s1) begin
			tcrc_q <= crc_next;
		end
	end

	assign out_valid = m_valid_q;
	assign out_char  = char_q;
	assign out_frame = line_frame(char_q);
	assign out_eos   = eos_q;

endmodule
